// ----- rtl/core/rfms_pkg.sv -----
`default_nettype none
package rfms_pkg;

   localparam int DATA_W    = 8;
   localparam int OPCODE_W  = 3;
   localparam int INDEX_W   = 8;
   localparam int COUNT_W   = 6;
   localparam int CAP_REG_W = 7;

   localparam logic [DATA_W-1:0] EMPTY_BYTE = 8'hFF;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE     = 3'd0,
      OP_DEQUEUE     = 3'd1,
      OP_PEEK_OLDEST = 3'd2,
      OP_PEEK_NEWEST = 3'd3,
      OP_CONTAINS    = 3'd4,
      OP_INDEX_VALID = 3'd5,
      OP_CLEAR       = 3'd6,
      OP_NOP         = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_SCAN = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/rfms_ram.sv -----
`default_nettype none
module rfms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ring_fifo_with_membership_search.sv -----
`default_nettype none
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+---------------------------
// request  | req_opcode, req_data_in, req_index             | beat on start && !busy
// response | rsp_data_out, rsp_ok, rsp_is_empty, rsp_is_full,| one-cycle beat on rsp_valid
//          | rsp_count                                      |
// csr      | csr_capacity                                   | beat on csr_valid && csr_ready
//
// Enqueue, index valid, clear and the unused opcode answer from ST_EXEC; dequeue and
// both peeks on a non-empty queue answer from ST_READ, paced by the registered read of
// the slot RAM. Contains walks the occupied slots through the single RAM read port, one
// slot per cycle, and answers once a byte matches or the scan reaches tail.
// The synchronous reset empties the queue and restores a capacity of 64, clamped to
// MAX_SLOTS. The receiver cannot stall: each response is shown for exactly one cycle.
module ring_fifo_with_membership_search #(
   parameter int MAX_SLOTS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [rfms_pkg::OPCODE_W-1:0]       req_opcode,
   input  wire logic [rfms_pkg::DATA_W-1:0]         req_data_in,
   input  wire logic [rfms_pkg::INDEX_W-1:0]        req_index,
   // Response channel.
   output logic                                     rsp_valid,
   output logic      [rfms_pkg::DATA_W-1:0]         rsp_data_out,
   output logic                                     rsp_ok,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_is_full,
   output logic      [rfms_pkg::COUNT_W-1:0]        rsp_count,
   // Capacity register write channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rfms_pkg::CAP_REG_W-1:0]      csr_capacity
);

   import rfms_pkg::*;

   // Slot pointers index the RAM; the ring size itself can reach MAX_SLOTS.
   localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CAP_W   = $clog2(MAX_SLOTS + 1);
   // Common width for comparing the 8-bit request index with pointers and the ring size.
   localparam int CMP_W   = INDEX_W + 1;
   localparam int CAP_RST = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

   state_type            state_ff,   state_in;
   logic [IDX_W-1:0]     head_ff,    head_in;
   logic [IDX_W-1:0]     tail_ff,    tail_in;
   logic [CAP_W-1:0]     cap_ff,     cap_in;
   logic [IDX_W-1:0]     scan_ff,    scan_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   op_type               op_ff,      op_in;
   logic [DATA_W-1:0]    key_ff,     key_in;
   logic [INDEX_W-1:0]   idx_ff,     idx_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [DATA_W-1:0]    dout_ff,    dout_in;
   logic                 ok_ff,      ok_in;

   logic                 wr_en;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [DATA_W-1:0]    rd_data;

   logic                 req_accept;
   logic                 csr_accept;
   logic                 q_empty;
   logic                 q_full;
   logic [IDX_W-1:0]     tail_next;
   logic [IDX_W-1:0]     head_next;
   logic [IDX_W-1:0]     newest;
   logic [CMP_W-1:0]     idx_x, head_x, tail_x, cap_x;
   logic                 idx_in_range;

   // Advance a pointer by one slot, wrapping at the ring size in use.
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i,
                                                  input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] inc;
      inc = CMP_W'(i) + CMP_W'(1);
      if (inc == CMP_W'(cap)) begin
         return '0;
      end
      return IDX_W'(inc);
   endfunction

   // Clamp a written capacity into the legal range 2 .. MAX_SLOTS.
   function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_REG_W-1:0] v);
      if (int'(v) < 2) begin
         return CAP_W'(2);
      end
      if (int'(v) > MAX_SLOTS) begin
         return CAP_W'(MAX_SLOTS);
      end
      return CAP_W'(v);
   endfunction

   assign busy       = (state_ff != ST_IDLE);
   assign req_accept = start && !busy;
   // A request beat wins over a capacity write offered in the same cycle.
   assign csr_ready  = (state_ff == ST_IDLE) && !start;
   assign csr_accept = csr_valid && csr_ready;

   // The pointers always stay below the ring size, since any capacity write
   // returns both of them to slot zero.
   assign tail_next = next_slot(tail_ff, cap_ff);
   assign head_next = next_slot(head_ff, cap_ff);
   assign newest    = (tail_ff == '0) ? IDX_W'(cap_ff - CAP_W'(1)) : tail_ff - IDX_W'(1);
   assign q_empty   = (head_ff == tail_ff);
   assign q_full    = (tail_next == head_ff);

   // Index check: contiguous range is head <= index < tail; a wrapped range covers
   // head up to the ring end plus everything below tail.
   assign idx_x  = CMP_W'(idx_ff);
   assign head_x = CMP_W'(head_ff);
   assign tail_x = CMP_W'(tail_ff);
   assign cap_x  = CMP_W'(cap_ff);
   always_comb begin
      if (head_x < tail_x) begin
         idx_in_range = (idx_x >= head_x) && (idx_x < tail_x);
      end else begin
         idx_in_range = ((idx_x >= head_x) && (idx_x < cap_x)) || (idx_x < tail_x);
      end
   end

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cap_in     = cap_ff;
      scan_in    = scan_ff;
      cmp_vld_in = cmp_vld_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      rsp_vld_in = 1'b0;
      dout_in    = dout_ff;
      ok_in      = ok_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_accept) begin
               // A new ring size starts from an empty queue; stored bytes stay.
               cap_in  = clamp_cap(csr_capacity);
               head_in = '0;
               tail_in = '0;
            end
            if (req_accept) begin
               op_in      = op_type'(req_opcode);
               key_in     = req_data_in;
               idx_in     = req_index;
               scan_in    = head_ff;
               cmp_vld_in = 1'b0;
               state_in   = (op_type'(req_opcode) == OP_CONTAINS) ? ST_SCAN : ST_EXEC;
            end
         end

         ST_EXEC: begin
            // Most opcodes finish here; a non-empty dequeue or peek launches one RAM read.
            dout_in    = '0;
            ok_in      = 1'b0;
            rsp_vld_in = 1'b1;
            state_in   = ST_IDLE;
            unique case (op_ff) inside
               OP_ENQUEUE: begin
                  if (!q_full) begin
                     wr_en   = 1'b1;
                     tail_in = tail_next;
                     ok_in   = 1'b1;
                  end
               end
               OP_DEQUEUE, OP_PEEK_OLDEST, OP_PEEK_NEWEST: begin
                  if (q_empty) begin
                     dout_in = EMPTY_BYTE;
                  end else begin
                     rd_en      = 1'b1;
                     rd_addr    = (op_ff == OP_PEEK_NEWEST) ? newest : head_ff;
                     rsp_vld_in = 1'b0;
                     state_in   = ST_READ;
                  end
               end
               OP_INDEX_VALID: begin
                  ok_in = !q_empty && idx_in_range;
               end
               OP_CLEAR: begin
                  head_in = '0;
                  tail_in = '0;
                  ok_in   = 1'b1;
               end
               default: begin
                  // The unused opcode only reports the current flags and count.
               end
            endcase
         end

         ST_READ: begin
            dout_in    = rd_data;
            ok_in      = 1'b1;
            rsp_vld_in = 1'b1;
            state_in   = ST_IDLE;
            if (op_ff == OP_DEQUEUE) begin
               head_in = head_next;
            end
         end

         ST_SCAN: begin
            // Each cycle compares the byte fetched last cycle and fetches the next slot,
            // so the final compare lands in the same cycle that sees the scan reach tail.
            dout_in = '0;
            if (cmp_vld_ff && (rd_data == key_ff)) begin
               ok_in      = 1'b1;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end else if (scan_ff == tail_ff) begin
               ok_in      = 1'b0;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = scan_ff;
               scan_in    = next_slot(scan_ff, cap_ff);
               cmp_vld_in = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         cap_ff     <= CAP_W'(CAP_RST);
         rsp_vld_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         cap_ff     <= cap_in;
         rsp_vld_ff <= rsp_vld_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      dout_ff <= dout_in;
      ok_ff   <= ok_in;
   end

   rfms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The pointers settle at the same edge that raises the response strobe, so the
   // flags and the count can be derived from them directly during the response beat.
   always_comb begin
      if (tail_x >= head_x) begin
         rsp_count = COUNT_W'(tail_x - head_x);
      end else begin
         rsp_count = COUNT_W'(tail_x + cap_x - head_x);
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_data_out = dout_ff;
   assign rsp_ok       = ok_ff;
   assign rsp_is_empty = q_empty;
   assign rsp_is_full  = q_full;

endmodule
`default_nettype wire
